FILE: rtl/gne_pkg.sv
package gne_pkg;

    // Block parameters.
    localparam int MAX_DIMS   = 3;
    localparam int MAX_WINDOW = 4;
    localparam int GRID_BITS  = 10;

    // Fixed field and register widths.
    localparam int NUM_AXES    = 3;
    localparam int COORD_W     = 16;
    localparam int DIMS_W      = 2;
    localparam int SIZE_REG_W  = 11;
    localparam int HW_W        = 9;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CNT_W       = 24;
    localparam int SNUM_W      = 25;
    localparam int VIDX_W      = 31;
    localparam int DSQ_W       = 18;
    localparam int FRAC_W      = 16;

    // Derived internal widths.
    localparam int SIZE_W    = GRID_BITS + 1;
    localparam int POS_W     = GRID_BITS;
    localparam int H16_W     = HW_W + 8;
    localparam int HSQ_W     = 2 * H16_W;
    localparam int M_W       = H16_W;
    localparam int LOC_W     = COORD_W + GRID_BITS + 2;
    localparam int DIFF_W    = LOC_W + 1;
    localparam int BND_W     = DIFF_W - FRAC_W;
    localparam int DIST_W    = 2 * M_W + 2;
    localparam int STRIDE2_W = 2 * GRID_BITS + 1;
    localparam int IP1_W     = POS_W + SIZE_W;
    localparam int IP2_W     = POS_W + STRIDE2_W;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DIMS_USED        = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X           = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y           = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z           = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_HALFWIDTH = CFG_INDEX_W'(4);

    // Register reset values.
    localparam logic [DIMS_W-1:0]     DIMS_RESET = DIMS_W'(3);
    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(256);
    localparam logic [HW_W-1:0]       HW_RESET   = HW_W'(256);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } sample_t;

    typedef struct packed {
        logic [SNUM_W-1:0] sample_number;
        logic [VIDX_W-1:0] voxel_index;
        logic [DSQ_W-1:0]  distance_sq;
        logic              last;
    } entry_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [NUM_AXES-1:0]             active;
        logic [NUM_AXES-1:0][SIZE_W-1:0] size;
        logic [H16_W-1:0]                h16;
        logic [HSQ_W-1:0]                hsq;
        logic [STRIDE2_W-1:0]            stride2;
    } cfg_t;

    // Clamped kernel window of one sample.
    typedef struct packed {
        logic [SNUM_W-1:0]              snum;
        logic                           empty;
        logic [NUM_AXES-1:0][LOC_W-1:0] loc;
        logic [NUM_AXES-1:0][POS_W-1:0] lo;
        logic [NUM_AXES-1:0][POS_W-1:0] hi;
    } window_t;

    // One voxel of a window.
    typedef struct packed {
        logic [SNUM_W-1:0]              snum;
        logic [NUM_AXES-1:0][LOC_W-1:0] loc;
        logic [NUM_AXES-1:0][POS_W-1:0] pos;
        logic                           last_voxel;
    } cand_t;

    // Evaluated voxel.
    typedef struct packed {
        entry_t entry;
        logic   in_support;
        logic   last_voxel;
    } result_t;

endpackage

FILE: rtl/gne_setup.sv
module gne_setup
    import gne_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    output logic    win_valid,
    input  logic    win_ready,
    output window_t win
);

    localparam logic signed [DIFF_W-1:0] ROUND_UP = DIFF_W'((1 << FRAC_W) - 1);
    localparam logic signed [BND_W-1:0]  WIN_SPAN = BND_W'(MAX_WINDOW - 1);
    localparam logic signed [BND_W-1:0]  ONE_BND  = BND_W'(1);

    logic [CNT_W-1:0] cnt_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    logic signed [COORD_W-1:0] coord [NUM_AXES];
    logic signed [LOC_W-1:0]   prod [NUM_AXES];
    logic [SIZE_W:0]           half [NUM_AXES];
    logic signed [DIFF_W-1:0]  lo_sum [NUM_AXES];
    logic signed [DIFF_W-1:0]  hi_sum [NUM_AXES];
    logic signed [BND_W-1:0]   lo_f [NUM_AXES];
    logic signed [BND_W-1:0]   hi_f [NUM_AXES];
    logic signed [BND_W-1:0]   smax [NUM_AXES];
    logic signed [BND_W-1:0]   cap [NUM_AXES];
    logic signed [BND_W-1:0]   hi2 [NUM_AXES];
    logic [NUM_AXES-1:0]       empty_a;

    logic [NUM_AXES-1:0][LOC_W-1:0] loc_next;
    logic [NUM_AXES-1:0][LOC_W-1:0] s1_loc_reg;
    logic [NUM_AXES-1:0][LOC_W-1:0] s2_loc_reg;
    logic [NUM_AXES-1:0][BND_W-1:0] lo_next;
    logic [NUM_AXES-1:0][BND_W-1:0] hi_next;
    logic [NUM_AXES-1:0][BND_W-1:0] s2_lo_reg;
    logic [NUM_AXES-1:0][BND_W-1:0] s2_hi_reg;
    logic [SNUM_W-1:0]              s1_snum_reg;
    logic [SNUM_W-1:0]              s2_snum_reg;
    window_t                        win_next;
    window_t                        win_reg;

    assign coord[0] = sample.coord_x;
    assign coord[1] = sample.coord_y;
    assign coord[2] = sample.coord_z;

    assign s3_ready     = !s3_valid_reg || win_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_ready = s1_ready;

    // Voxel-space position with 16 fraction bits: coord*size*2 + ceil(size/2).
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            prod[a] = coord[a] * $signed({1'b0, cfg.size[a]});
            half[a] = ({1'b0, cfg.size[a]} + 1'b1) >> 1;
            if (cfg.active[a])
            begin
                loc_next[a] = $signed({prod[a][LOC_W-2:0], 1'b0})
                            + $signed({half[a], FRAC_W'(0)});
            end
            else
            begin
                loc_next[a] = '0;
            end
        end
    end

    // Raw window bounds, clamped to the grid edges.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo_sum[a] = DIFF_W'($signed(s1_loc_reg[a])) - $signed(DIFF_W'(cfg.h16)) + ROUND_UP;
            hi_sum[a] = DIFF_W'($signed(s1_loc_reg[a])) + $signed(DIFF_W'(cfg.h16));
            lo_f[a]   = lo_sum[a][DIFF_W-1:FRAC_W];
            hi_f[a]   = hi_sum[a][DIFF_W-1:FRAC_W];
            smax[a]   = $signed(BND_W'(cfg.size[a])) - ONE_BND;
            lo_next[a] = lo_f[a][BND_W-1] ? '0 : lo_f[a];
            hi_next[a] = (hi_f[a] > smax[a]) ? smax[a] : hi_f[a];
        end
    end

    // Window length cap and emptiness.
    always_comb
    begin
        win_next.snum = s2_snum_reg;
        win_next.loc  = s2_loc_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            cap[a] = $signed(s2_lo_reg[a]) + WIN_SPAN;
            hi2[a] = ($signed(s2_hi_reg[a]) > cap[a]) ? cap[a] : $signed(s2_hi_reg[a]);
            empty_a[a] = cfg.active[a] && (hi2[a] < $signed(s2_lo_reg[a]));
            win_next.lo[a] = cfg.active[a] ? s2_lo_reg[a][POS_W-1:0] : '0;
            win_next.hi[a] = cfg.active[a] ? hi2[a][POS_W-1:0] : '0;
        end
        win_next.empty = |empty_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_valid && s1_ready)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && s1_ready)
        begin
            s1_loc_reg  <= loc_next;
            s1_snum_reg <= {1'b0, cnt_reg} + 1'b1;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_loc_reg  <= s1_loc_reg;
            s2_snum_reg <= s1_snum_reg;
            s2_lo_reg   <= lo_next;
            s2_hi_reg   <= hi_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            win_reg <= win_next;
        end
    end

    assign win_valid = s3_valid_reg;
    assign win       = win_reg;

`ifndef SYNTHESIS
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("sample counter did not advance on an accepted item");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_valid && sample_ready) |=> $stable(cnt_reg))
        else $error("sample counter moved without an accepted item");
`endif

endmodule

FILE: rtl/gne_walker.sv
module gne_walker
    import gne_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    win_valid,
    output logic    win_ready,
    input  window_t win,
    output logic    cand_valid,
    input  logic    cand_ready,
    output cand_t   cand
);

    logic                           busy_reg;
    window_t                        cur_reg;
    logic [NUM_AXES-1:0][POS_W-1:0] pos_reg;
    logic [NUM_AXES-1:0][POS_W-1:0] pos_next;
    logic [NUM_AXES-1:0]            at_hi;
    logic                           last_voxel;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            at_hi[a] = (pos_reg[a] == cur_reg.hi[a]);
        end
    end

    assign last_voxel = &at_hi;
    assign win_ready  = !busy_reg || (cand_ready && last_voxel);

    // Odometer step: first axis fastest, wrapping to the lower bound.
    always_comb
    begin
        logic carry;
        carry    = 1'b1;
        pos_next = pos_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (carry)
            begin
                if (at_hi[a])
                begin
                    pos_next[a] = cur_reg.lo[a];
                end
                else
                begin
                    pos_next[a] = pos_reg[a] + 1'b1;
                    carry       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (win_ready)
        begin
            busy_reg <= win_valid && !win.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_ready && win_valid)
        begin
            cur_reg <= win;
            pos_reg <= win.lo;
        end
        else if (busy_reg && cand_ready)
        begin
            pos_reg <= pos_next;
        end
    end

    assign cand_valid      = busy_reg;
    assign cand.snum       = cur_reg.snum;
    assign cand.loc        = cur_reg.loc;
    assign cand.pos        = pos_reg;
    assign cand.last_voxel = last_voxel;

`ifndef SYNTHESIS
    a_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg[0] >= cur_reg.lo[0] && pos_reg[0] <= cur_reg.hi[0]
                   && pos_reg[1] >= cur_reg.lo[1] && pos_reg[1] <= cur_reg.hi[1]
                   && pos_reg[2] >= cur_reg.lo[2] && pos_reg[2] <= cur_reg.hi[2]))
        else $error("walker position left its window");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid && win_ready && !win.empty) |=> busy_reg)
        else $error("non-empty window taken but walk not started");
`endif

endmodule

FILE: rtl/gne_voxel.sv
module gne_voxel
    import gne_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cand_valid,
    output logic    cand_ready,
    input  cand_t   cand,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam logic [DIST_W-1:0] HALF_LSB = DIST_W'(1 << (FRAC_W - 1));

    logic v1_valid_reg;
    logic v2_valid_reg;
    logic v3_valid_reg;
    logic v1_ready;
    logic v2_ready;
    logic v3_ready;

    logic signed [DIFF_W-1:0] diff [NUM_AXES];
    logic [NUM_AXES-1:0][M_W-1:0]   mag_next;
    logic [NUM_AXES-1:0][M_W-1:0]   mag_reg;
    logic [IP1_W-1:0]               ip1_reg;
    logic [IP2_W-1:0]               ip2_reg;
    logic [POS_W-1:0]               x_reg;
    logic [SNUM_W-1:0]              v1_snum_reg;
    logic                           v1_last_reg;

    logic [NUM_AXES-1:0][HSQ_W-1:0] sq_reg;
    logic [VIDX_W-1:0]              vidx_reg;
    logic [SNUM_W-1:0]              v2_snum_reg;
    logic                           v2_last_reg;

    logic [DIST_W-1:0]              dist_sum;
    logic [DIST_W-1:0]              dist_rnd;
    result_t                        res_next;
    result_t                        res_reg;

    assign v3_ready   = !v3_valid_reg || res_ready;
    assign v2_ready   = !v2_valid_reg || v3_ready;
    assign v1_ready   = !v1_valid_reg || v2_ready;
    assign cand_ready = v1_ready;

    // Offset from the sample on each axis; it never exceeds the half width.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff[a] = $signed(DIFF_W'({cand.pos[a], FRAC_W'(0)}))
                    - DIFF_W'($signed(cand.loc[a]));
            mag_next[a] = diff[a][DIFF_W-1] ? M_W'(-diff[a]) : M_W'(diff[a]);
        end
    end

    always_comb
    begin
        dist_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        dist_rnd = dist_sum + HALF_LSB;
        res_next.entry.sample_number = v2_snum_reg;
        res_next.entry.voxel_index   = vidx_reg;
        res_next.entry.distance_sq   = dist_rnd[FRAC_W+DSQ_W-1:FRAC_W];
        res_next.entry.last          = 1'b0;
        res_next.in_support          = (dist_sum <= DIST_W'(cfg.hsq));
        res_next.last_voxel          = v2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
        end
        else
        begin
            if (v1_ready)
            begin
                v1_valid_reg <= cand_valid;
            end
            if (v2_ready)
            begin
                v2_valid_reg <= v1_valid_reg;
            end
            if (v3_ready)
            begin
                v3_valid_reg <= v2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_valid && v1_ready)
        begin
            mag_reg     <= mag_next;
            ip1_reg     <= cand.pos[1] * cfg.size[0];
            ip2_reg     <= cand.pos[2] * cfg.stride2;
            x_reg       <= cand.pos[0];
            v1_snum_reg <= cand.snum;
            v1_last_reg <= cand.last_voxel;
        end
        if (v1_valid_reg && v2_ready)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sq_reg[a] <= mag_reg[a] * mag_reg[a];
            end
            vidx_reg    <= VIDX_W'(1) + VIDX_W'(x_reg) + VIDX_W'(ip1_reg) + VIDX_W'(ip2_reg);
            v2_snum_reg <= v1_snum_reg;
            v2_last_reg <= v1_last_reg;
        end
        if (v2_valid_reg && v3_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = v3_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/gne_out.sv
module gne_out
    import gne_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    entry_valid,
    input  logic    entry_stall,
    output entry_t  entry
);

    // pend holds the newest in-support voxel until it is known whether a
    // further one of the same sample follows.
    logic   pend_valid_reg;
    logic   pend_done_reg;
    entry_t pend_reg;
    logic   out_valid_reg;
    entry_t out_reg;

    logic out_free;
    logic push;
    logic take;
    logic load;
    logic resolve;

    assign out_free = !out_valid_reg || !entry_stall;

    always_comb
    begin
        push    = 1'b0;
        take    = 1'b0;
        load    = 1'b0;
        resolve = 1'b0;
        if (pend_valid_reg && pend_done_reg)
        begin
            push = out_free;
            take = out_free;
            load = out_free && res_valid && res.in_support;
        end
        else if (pend_valid_reg)
        begin
            if (res.in_support)
            begin
                push = out_free && res_valid;
                take = out_free;
                load = out_free && res_valid;
            end
            else
            begin
                take    = 1'b1;
                resolve = res_valid && res.last_voxel;
            end
        end
        else
        begin
            take = 1'b1;
            load = res_valid && res.in_support;
        end
    end

    assign res_ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pend_valid_reg <= 1'b1;
                pend_done_reg  <= res.last_voxel;
            end
            else
            begin
                if (push)
                begin
                    pend_valid_reg <= 1'b0;
                end
                if (resolve)
                begin
                    pend_done_reg <= 1'b1;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!entry_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pend_reg <= res.entry;
        end
        if (push)
        begin
            out_reg <= '{sample_number: pend_reg.sample_number,
                         voxel_index:   pend_reg.voxel_index,
                         distance_sq:   pend_reg.distance_sq,
                         last:          pend_done_reg};
        end
    end

    assign entry_valid = out_valid_reg;
    assign entry       = out_reg;

`ifndef SYNTHESIS
    a_follow_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last)
            |-> (pend_valid_reg && pend_reg.sample_number == out_reg.sample_number))
        else $error("entry without last flag has no follow-on entry of its sample");
`endif

endmodule

FILE: rtl/gridding_neighbor_enumerator.sv
// Kernel support search for convolution gridding. Each item is one sample
// coordinate (Q1.15 fraction of the field of view per axis); the block maps
// it to voxel space, clamps the kernel window to the grid and returns one
// entry for every voxel within the kernel half width, with the first axis
// fastest and the last entry of a sample flagged. The voxel walker steps
// through a sample's window of nx*ny*nz voxels one voxel per cycle while
// the voxel stage accepts, with windows of up to four voxels per axis; a
// sample with an empty window passes the walker and gives no entry. Up to
// three samples queue in the bound pipeline ahead of the walker while it
// is busy. An entry is only shown once the next voxel of its sample in
// support, or the end of its window, has been seen.
// Configuration registers take effect on the next item and must only be
// written while no item is in flight.
module gridding_neighbor_enumerator
    import gne_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   entry_valid,
    input  logic                   entry_stall,
    output entry_t                 entry,
    input  logic                   cfg_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [SIZE_REG_W-1:0] SIZE_CAP = SIZE_REG_W'(1 << GRID_BITS);

    // Raw configuration registers, as written through the port.
    logic [DIMS_W-1:0]     dims_used_reg;
    logic [SIZE_REG_W-1:0] size_x_reg;
    logic [SIZE_REG_W-1:0] size_y_reg;
    logic [SIZE_REG_W-1:0] size_z_reg;
    logic [HW_W-1:0]       kernel_halfwidth_reg;

    // Derived values; the products are registered since they are only needed
    // several stages after an item is accepted.
    logic [DIMS_W-1:0]              dims_eff;
    logic [NUM_AXES-1:0][SIZE_W-1:0] size_eff;
    logic [H16_W-1:0]               h16;
    logic [HSQ_W-1:0]               hsq_reg;
    logic [STRIDE2_W-1:0]           stride2_reg;
    cfg_t                           cfg;

    logic    sample_ready;
    logic    win_valid;
    logic    win_ready;
    window_t win;
    logic    cand_valid;
    logic    cand_ready;
    cand_t   cand;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // A grid size above the supported maximum is saturated to it.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_REG_W-1:0] raw);
        return (raw > SIZE_CAP) ? SIZE_CAP[SIZE_W-1:0] : raw[SIZE_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_used_reg        <= DIMS_RESET;
            size_x_reg           <= SIZE_RESET;
            size_y_reg           <= SIZE_RESET;
            size_z_reg           <= SIZE_RESET;
            kernel_halfwidth_reg <= HW_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_DIMS_USED:        dims_used_reg        <= cfg_data[DIMS_W-1:0];
                REG_SIZE_X:           size_x_reg           <= cfg_data[SIZE_REG_W-1:0];
                REG_SIZE_Y:           size_y_reg           <= cfg_data[SIZE_REG_W-1:0];
                REG_SIZE_Z:           size_z_reg           <= cfg_data[SIZE_REG_W-1:0];
                REG_KERNEL_HALFWIDTH: kernel_halfwidth_reg <= cfg_data[HW_W-1:0];
                default:              ;
            endcase
        end
    end

    // A dimension count of zero means one axis; counts beyond the supported
    // number of axes are cut to it.
    always_comb
    begin
        dims_eff = dims_used_reg;
        if (dims_used_reg == '0)
        begin
            dims_eff = DIMS_W'(1);
        end
        else if (int'(dims_used_reg) > MAX_DIMS)
        begin
            dims_eff = DIMS_W'(MAX_DIMS);
        end
    end

    assign size_eff[0] = eff_size(size_x_reg);
    assign size_eff[1] = eff_size(size_y_reg);
    assign size_eff[2] = eff_size(size_z_reg);

    // Half width moves from 1/256 voxel to the 16-bit fraction of voxel space.
    assign h16 = {kernel_halfwidth_reg, 8'b0};

    always_ff @(posedge clk)
    begin
        hsq_reg     <= h16 * h16;
        stride2_reg <= STRIDE2_W'(size_eff[0] * size_eff[1]);
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            cfg.active[a] = (a < int'(dims_eff));
        end
        cfg.size    = size_eff;
        cfg.h16     = h16;
        cfg.hsq     = hsq_reg;
        cfg.stride2 = stride2_reg;
    end

    assign sample_stall = !sample_ready;

    // Three stages: voxel-space position, raw bounds, clamped window.
    gne_setup u_setup (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win          (win)
    );

    // Walks the window one voxel per cycle while the voxel stage accepts.
    gne_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win        (win),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand)
    );

    // Three stages: offsets and index products, squares and index sum,
    // distance sum with support test and rounding.
    gne_voxel u_voxel (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Drops voxels out of support and holds one entry back to place the
    // last flag.
    gne_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry       (entry)
    );

endmodule
